>>> hdl/nlv_pkg.sv
// ----------------------------------------------------------------------------
// nlv_pkg
// Shared types and constants for the numeric literal validator.
// ----------------------------------------------------------------------------
package nlv_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned OutTdataW = 8;

    // characters that the grammar treats specially
    localparam logic [ByteW-1:0] CharTerm  = 8'h00;
    localparam logic [ByteW-1:0] CharDot   = 8'h2E;
    localparam logic [ByteW-1:0] CharLowE  = 8'h65;
    localparam logic [ByteW-1:0] CharUpE   = 8'h45;
    localparam logic [ByteW-1:0] CharMinus = 8'h2D;
    localparam logic [ByteW-1:0] CharPlus  = 8'h2B;
    localparam logic [ByteW-1:0] CharZero  = 8'h30;
    localparam logic [ByteW-1:0] CharNine  = 8'h39;

    // position in the literal grammar
    typedef enum logic [3:0] {
        ST_START   = 4'd0,
        ST_SIGN    = 4'd1,
        ST_INTDIG  = 4'd2,
        ST_FRACDIG = 4'd3,
        ST_LEADDOT = 4'd4,
        ST_EXPMARK = 4'd5,
        ST_EXPSIGN = 4'd6,
        ST_EXPDIG  = 4'd7,
        ST_REJECT  = 4'd8
    } gram_state_t;

    // registered input item handed to the recogniser
    typedef struct packed {
        logic             valid;
        logic [ByteW-1:0] text_byte;
    } in_item_t;

    // character class decode
    typedef struct packed {
        logic term;
        logic dig;
        logic sgn;
        logic dot;
        logic exm;
    } char_class_t;

endpackage

>>> hdl/nlv_in_stage.sv
// ----------------------------------------------------------------------------
// nlv_in_stage
// Input register: holds one text byte until the recogniser consumes it.
// ----------------------------------------------------------------------------
module nlv_in_stage
    import nlv_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [ByteW-1:0] s_tdata,   // [7:0] text_byte
    input  logic             advance,
    output in_item_t         item
);

    logic             valid_reg;
    logic             valid_next;
    logic [ByteW-1:0] byte_reg;
    logic [ByteW-1:0] byte_next;

    // slot is free when empty or being drained this cycle
    assign s_tready = !valid_reg || advance;

    // next item and valid flag
    always_comb begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
            if (s_tvalid) begin
                byte_next = s_tdata;
            end
        end
    end

    // control register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload register
    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign item.valid     = valid_reg;
    assign item.text_byte = byte_reg;

endmodule

>>> hdl/nlv_grammar.sv
// ----------------------------------------------------------------------------
// nlv_grammar
// Grammar state machine and result register for the literal recogniser.
// ----------------------------------------------------------------------------
module nlv_grammar
    import nlv_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  in_item_t             item,
    output logic                 advance,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OutTdataW-1:0] m_tdata    // [0] is_integer, [1] is_float, [7:2] zero
);

    gram_state_t state_reg;
    gram_state_t state_next;
    char_class_t cls;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_int_reg;
    logic        out_int_next;
    logic        out_float_reg;
    logic        out_float_next;
    logic        flag_int;
    logic        flag_float;

    // character class decode
    always_comb begin
        cls.term = (item.text_byte == CharTerm);
        cls.dig  = (item.text_byte inside {[CharZero:CharNine]});
        cls.sgn  = (item.text_byte inside {CharPlus, CharMinus});
        cls.dot  = (item.text_byte == CharDot);
        cls.exm  = (item.text_byte inside {CharLowE, CharUpE});
    end

    // an ordinary byte always moves on; a terminator needs the result slot
    assign advance = item.valid && (!cls.term || !out_valid_reg || m_tready);

    // next state
    always_comb begin
        state_next = state_reg;
        if (advance) begin
            if (cls.term) begin
                state_next = ST_START;
            end else begin
                case (state_reg)
                    ST_START: begin
                        if (cls.sgn)      state_next = ST_SIGN;
                        else if (cls.dig) state_next = ST_INTDIG;
                        else if (cls.dot) state_next = ST_LEADDOT;
                        else              state_next = ST_REJECT;
                    end
                    ST_SIGN: begin
                        if (cls.dig)      state_next = ST_INTDIG;
                        else if (cls.dot) state_next = ST_LEADDOT;
                        else              state_next = ST_REJECT;
                    end
                    ST_INTDIG: begin
                        if (cls.dig)      state_next = ST_INTDIG;
                        else if (cls.dot) state_next = ST_FRACDIG;
                        else if (cls.exm) state_next = ST_EXPMARK;
                        else              state_next = ST_REJECT;
                    end
                    ST_FRACDIG: begin
                        if (cls.dig)      state_next = ST_FRACDIG;
                        else if (cls.exm) state_next = ST_EXPMARK;
                        else              state_next = ST_REJECT;
                    end
                    ST_LEADDOT: begin
                        if (cls.dig) state_next = ST_FRACDIG;
                        else         state_next = ST_REJECT;
                    end
                    ST_EXPMARK: begin
                        if (cls.sgn)      state_next = ST_EXPSIGN;
                        else if (cls.dig) state_next = ST_EXPDIG;
                        else              state_next = ST_REJECT;
                    end
                    ST_EXPSIGN: begin
                        if (cls.dig) state_next = ST_EXPDIG;
                        else         state_next = ST_REJECT;
                    end
                    ST_EXPDIG: begin
                        if (cls.dig) state_next = ST_EXPDIG;
                        else         state_next = ST_REJECT;
                    end
                    default: begin
                        state_next = ST_REJECT;
                    end
                endcase
            end
        end
    end

    // acceptance flags from the current position
    always_comb begin
        flag_int   = (state_reg == ST_INTDIG);
        flag_float = (state_reg == ST_INTDIG) || (state_reg == ST_FRACDIG) ||
                     (state_reg == ST_EXPDIG);
    end

    // result slot: load on terminator, clear when taken
    always_comb begin
        out_valid_next = out_valid_reg;
        out_int_next   = out_int_reg;
        out_float_next = out_float_reg;
        if (advance && cls.term) begin
            out_valid_next = 1'b1;
            out_int_next   = flag_int;
            out_float_next = flag_float;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_START;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        out_int_reg   <= out_int_next;
        out_float_reg <= out_float_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutTdataW-2){1'b0}}, out_float_reg, out_int_reg};

endmodule

>>> hdl/numeric_literal_validator.sv
// ----------------------------------------------------------------------------
// numeric_literal_validator
// Checks a zero-terminated text stream for integer and float literal syntax.
// ----------------------------------------------------------------------------
//  channel   | direction | tdata (low bit first)             | items
//  s_        | in        | [7:0] text_byte                   | one per character
//  m_        | out       | [0] is_integer, [1] is_float      | one per terminator
//
//  One item per cycle is taken unless a stalled result holds a terminator;
//  each byte is registered in the input register before the grammar state
//  machine consumes it. A result is loaded into the result register as its
//  terminator is consumed from the input register.
//  Reset (aresetn low, synchronous) empties both registers and returns the
//  grammar to the start of string.
//  A stalled result blocks only a terminator in the input register; the
//  bytes behind that terminator wait with it.
// ----------------------------------------------------------------------------
module numeric_literal_validator
    import nlv_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [ByteW-1:0]     s_tdata,   // [7:0] text_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OutTdataW-1:0] m_tdata    // [0] is_integer, [1] is_float, [7:2] zero
);

    in_item_t item;
    logic     advance;

    // input register
    nlv_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .item     (item)
    );

    // grammar tracking and result register
    nlv_grammar u_grammar (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .item     (item),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
